[rtl/core/sms_seg_pkg.sv]
// ----------------------------------------------------------------------------
// sms_seg_pkg
// Shared types, constants and the GSM 7-bit alphabet lookup of the SMS
// segment counter.
// ----------------------------------------------------------------------------
package sms_seg_pkg;

	localparam int MAX_UNITS = 4096;

	localparam int SEPTET_W = 13;
	localparam int UNIT_W   = 12;
	localparam int PART_W   = 6;
	localparam int CODE_W   = 16;

	localparam logic [SEPTET_W-1:0] SEPTET_MAX = {SEPTET_W{1'b1}};
	localparam int UNIT_CAP_INT = ((MAX_UNITS - 1) < 4095) ? (MAX_UNITS - 1) : 4095;
	localparam logic [UNIT_W-1:0] UNIT_CAP = UNIT_CAP_INT[UNIT_W-1:0];

	localparam logic [SEPTET_W-1:0] GSM_SINGLE_MAX  = 13'd160;
	localparam logic [UNIT_W-1:0]   UCS2_SINGLE_MAX = 12'd70;

	// floor(x / 153) and floor(x / 67) as (x * RECIP) >> RECIP_SHIFT, exact
	// over the full counter range
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 14;
	localparam logic [RECIP_W-1:0] GSM_RECIP  = 14'd6854;
	localparam logic [RECIP_W-1:0] UCS2_RECIP = 14'd15651;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_BASIC,
		CLS_EXT,
		CLS_NONE
	} unit_class_t;

	typedef struct packed {
		logic                all_gsm;
		logic [SEPTET_W-1:0] septets;
		logic [UNIT_W-1:0]   units;
	} msg_totals_t;

	function automatic unit_class_t classify_unit(input logic [CODE_W-1:0] u);
		unit_class_t c;
		c = CLS_NONE;
		unique case (u)
			16'h0000: c = CLS_ZERO;
			16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9,
			16'h00EC, 16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D,
			16'h00C5, 16'h00E5, 16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B,
			16'h03A9, 16'h03A0, 16'h03A8, 16'h03A3, 16'h0398, 16'h039E, 16'h001B,
			16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9, 16'h0020, 16'h0021, 16'h0022,
			16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027, 16'h0028, 16'h0029,
			16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F, 16'h0030,
			16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
			16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E,
			16'h003F, 16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045,
			16'h0046, 16'h0047, 16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C,
			16'h004D, 16'h004E, 16'h004F, 16'h0050, 16'h0051, 16'h0052, 16'h0053,
			16'h0054, 16'h0055, 16'h0056, 16'h0057, 16'h0058, 16'h0059, 16'h005A,
			16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7, 16'h00BF, 16'h0061,
			16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067, 16'h0068,
			16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
			16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076,
			16'h0077, 16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1,
			16'h00FC, 16'h00E0: c = CLS_BASIC;
			16'h20AC, 16'h000C, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h007B,
			16'h007C, 16'h007D, 16'h007E: c = CLS_EXT;
			default: c = CLS_NONE;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/sms_seg_parts.sv]
// ----------------------------------------------------------------------------
// sms_seg_parts
// Segment count of a finished message: single part at or below the threshold,
// otherwise a ceiling division by the per-part payload via reciprocal multiply.
// ----------------------------------------------------------------------------
module sms_seg_parts (
	input  sms_seg_pkg::msg_totals_t          totals,
	output logic [sms_seg_pkg::PART_W-1:0]    part_count
);
	import sms_seg_pkg::*;

	localparam int PROD_W = SEPTET_W + RECIP_W;

	logic [SEPTET_W-1:0] num;
	logic [RECIP_W-1:0]  recip;
	logic [PROD_W-1:0]   prod;
	logic                single;

	always_comb begin
		if (totals.all_gsm) begin
			num    = totals.septets - SEPTET_W'(1);
			recip  = GSM_RECIP;
			single = (totals.septets <= GSM_SINGLE_MAX);
		end else begin
			num    = SEPTET_W'(totals.units) - SEPTET_W'(1);
			recip  = UCS2_RECIP;
			single = (totals.units <= UCS2_SINGLE_MAX);
		end
		prod = PROD_W'(num) * PROD_W'(recip);
		if (single) begin
			part_count = PART_W'(1);
		end else begin
			part_count = prod[RECIP_SHIFT +: PART_W] + PART_W'(1);
		end
	end

endmodule

[rtl/core/sms_segment_counter_top.sv]
// ----------------------------------------------------------------------------
// sms_segment_counter_top
// Counts GSM 7-bit septets and UCS-2 units of a message and reports the
// number of SMS parts it needs on its last unit.
// ----------------------------------------------------------------------------
// One UCS-2 code unit is accepted every cycle while in_ready is high. Each
// unit is registered, looked up in the GSM alphabet and folded into the
// message counters in the next cycle; the counter update is a single saturating
// add per cycle, which sets the rate of one unit per clock. The totals of a
// message are registered after the lookup and counter update, and the segment
// division of them goes into the output register. Counters clear as the last
// unit is folded in, so the next message may follow without a gap. Two results
// can wait on out_ready; while both are held, a last unit stalls in the input
// register and the input stalls behind it.
module sms_segment_counter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sms_seg_pkg::CODE_W-1:0]      code_unit,
	input  logic                                last_unit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sms_seg_pkg::PART_W-1:0]      part_count,
	output logic                                fits_gsm7,
	output logic [sms_seg_pkg::SEPTET_W-1:0]    septet_total,
	output logic [sms_seg_pkg::UNIT_W-1:0]      unit_total
);
	import sms_seg_pkg::*;

	logic                valid_s1;
	logic [CODE_W-1:0]   code_s1;
	logic                last_s1;

	logic                valid_s2;
	msg_totals_t         tot_s2;

	logic                out_valid_q;
	logic [PART_W-1:0]   part_q;
	msg_totals_t         tot_q;

	logic [SEPTET_W-1:0] septet_q;
	logic [UNIT_W-1:0]   unit_q;
	logic                all_gsm_q;

	logic                en_out;
	logic                en2;
	logic                consume1;
	logic                en1;

	unit_class_t         cls;
	logic [SEPTET_W:0]   septet_sum;
	logic [UNIT_W:0]     unit_sum;
	msg_totals_t         tot_next;
	logic [PART_W-1:0]   part_next;

	assign en_out   = !out_valid_q || out_ready;
	assign en2      = !valid_s2 || en_out;
	assign consume1 = valid_s1 && (!last_s1 || en2);
	assign en1      = !valid_s1 || consume1;
	assign in_ready = en1;

	always_comb begin
		cls        = classify_unit(code_s1);
		septet_sum = {1'b0, septet_q};
		unique case (cls)
			CLS_BASIC: septet_sum = {1'b0, septet_q} + (SEPTET_W+1)'(1);
			CLS_EXT:   septet_sum = {1'b0, septet_q} + (SEPTET_W+1)'(2);
			CLS_ZERO,
			CLS_NONE:  septet_sum = {1'b0, septet_q};
			default:   septet_sum = {1'b0, septet_q};
		endcase
		unit_sum = {1'b0, unit_q} + (UNIT_W+1)'(1);

		tot_next.all_gsm = all_gsm_q && (cls != CLS_NONE);
		tot_next.septets = (septet_sum > {1'b0, SEPTET_MAX}) ? SEPTET_MAX
		                                                     : septet_sum[SEPTET_W-1:0];
		tot_next.units   = (unit_sum > {1'b0, UNIT_CAP}) ? UNIT_CAP : unit_sum[UNIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			code_s1 <= code_unit;
			last_s1 <= last_unit;
		end
	end

	// fold the unit in; clear for the next message on the last unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			septet_q  <= '0;
			unit_q    <= '0;
			all_gsm_q <= 1'b1;
		end else if (consume1) begin
			if (last_s1) begin
				septet_q  <= '0;
				unit_q    <= '0;
				all_gsm_q <= 1'b1;
			end else begin
				septet_q  <= tot_next.septets;
				unit_q    <= tot_next.units;
				all_gsm_q <= tot_next.all_gsm;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= consume1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && consume1 && last_s1) begin
			tot_s2 <= tot_next;
		end
	end

	sms_seg_parts u_parts (
		.totals     (tot_s2),
		.part_count (part_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			part_q <= part_next;
			tot_q  <= tot_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign part_count   = part_q;
	assign fits_gsm7    = tot_q.all_gsm;
	assign septet_total = tot_q.septets;
	assign unit_total   = tot_q.units;

`ifndef SYNTH
	a_part_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (part_q != '0) && (part_q <= PART_W'(62)))
		else $error("part count out of range");

	a_single_gsm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tot_q.all_gsm && (tot_q.septets <= GSM_SINGLE_MAX))
		|-> (part_q == PART_W'(1)))
		else $error("short GSM message not a single part");

	a_unit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		unit_q <= UNIT_CAP)
		else $error("unit counter above cap");

	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && !en2) |-> !in_ready)
		else $error("accepted item while last unit stalled");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(consume1 && last_s1) |=> (unit_q == '0) && (septet_q == '0) && all_gsm_q)
		else $error("counters not cleared after last unit");
`endif

endmodule
